[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the core design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rmm_pkg.sv]
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants of the range min/max swap tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmm_pkg;

   localparam int IDX_W    = 10;           // array position width
   localparam int NODE_W   = IDX_W + 1;    // tree node address width
   localparam int LR_W     = IDX_W + 2;    // query bound width (reaches 2*items)
   localparam int SIZE_W   = 11;
   localparam int NODES    = 1 << NODE_W;
   localparam int ITEMS    = 1 << IDX_W;

   localparam logic [SIZE_W-1:0] MAX_ITEMS  = 11'd1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [1:0] MODE_SWAP  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_INIT  = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [IDX_W-1:0] index_a;
      logic [IDX_W-1:0] index_b;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] range_min;
      logic [IDX_W-1:0]  range_max;
      logic              is_exact;
      logic              range_empty;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT_START,
      ST_BUILD,
      ST_IDLE,
      ST_SWAP_READ,
      ST_PATH_A_START,
      ST_PATH_A,
      ST_PATH_B_START,
      ST_PATH_B,
      ST_QUERY_START,
      ST_QUERY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic size_update;
      logic build_init;
      logic build_step;
      logic swap_read;
      logic path_start;
      logic path_sel_b;
      logic path_step;
      logic query_start;
      logic query_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic build_last;
      logic swap_ok;
      logic path_root;
      logic query_idle;
      logic out_free;
   } status_type;

endpackage

[design/rmm_ctrl.sv]
// ----------------------------------------------------------------------------
// rmm_ctrl
// Sequencer: build sweep, swap path walks, query walk, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmm_ctrl
   import rmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_INIT_START: begin
            cmd.build_init = 1'b1;
            state_in       = ST_BUILD;
         end
         ST_BUILD: begin
            cmd.build_step = 1'b1;
            if (status.build_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_mode)
                  MODE_SWAP:  state_in = ST_SWAP_READ;
                  MODE_QUERY: state_in = ST_QUERY_START;
                  MODE_INIT: begin
                     cmd.size_update = 1'b1;
                     cmd.build_init  = 1'b1;
                     state_in        = ST_BUILD;
                  end
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWAP_READ: begin
            cmd.swap_read = 1'b1;
            state_in = status.swap_ok ? ST_PATH_A_START : ST_IDLE;
         end
         ST_PATH_A_START: begin
            cmd.path_start = 1'b1;
            state_in       = ST_PATH_A;
         end
         ST_PATH_A: begin
            cmd.path_step = 1'b1;
            if (status.path_root) begin
               state_in = ST_PATH_B_START;
            end
         end
         ST_PATH_B_START: begin
            cmd.path_start = 1'b1;
            cmd.path_sel_b = 1'b1;
            state_in       = ST_PATH_B;
         end
         ST_PATH_B: begin
            cmd.path_step = 1'b1;
            if (status.path_root) begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY_START: begin
            cmd.query_start = 1'b1;
            state_in        = ST_QUERY;
         end
         ST_QUERY: begin
            cmd.query_step = 1'b1;
            if (status.query_idle) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT_START;
      endcase
   end

endmodule

[design/rmm_datapath.sv]
// ----------------------------------------------------------------------------
// rmm_datapath
// Value store, min/max tree memories, walk registers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmm_datapath
   import rmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   logic [IDX_W-1:0]  value_mem [ITEMS];
   logic [NODE_W-1:0] min_mem   [NODES];
   logic [IDX_W-1:0]  max_mem   [NODES];

   req_type           req_ff;
   logic [SIZE_W-1:0] items_ff, size_ff;
   logic [NODE_W-1:0] node_ff;
   logic [3:0]        shift_ff;
   logic [IDX_W-1:0]  va_ff, vb_ff;
   logic [NODE_W-1:0] cur_min_ff;
   logic [IDX_W-1:0]  cur_max_ff;
   logic [LR_W-1:0]   l_ff, r_ff;
   logic              pl_ff, pr_ff;
   logic [NODE_W-1:0] lo_ff;
   logic [IDX_W-1:0]  hi_ff;
   logic              empty_ff;
   logic [NODE_W-1:0] rd0_min_ff, rd1_min_ff;
   logic [IDX_W-1:0]  rd0_max_ff, rd1_max_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // build: node n covers an aligned leaf block
   logic [NODE_W-1:0] build_shl;
   logic [IDX_W-1:0]  build_lo, build_hi;
   logic [NODE_W-1:0] node_inc;

   logic [IDX_W-1:0]  path_pos, path_val;
   logic [NODE_W-1:0] path_leaf;
   logic [NODE_W-1:0] step_min;
   logic [IDX_W-1:0]  step_max;

   logic              we;
   logic [NODE_W-1:0] waddr, wmin, rd0_addr, rd1_addr;
   logic [IDX_W-1:0]  wmax;

   logic              q_ok, lt;
   logic [LR_W-1:0]   r_m1;
   logic [NODE_W-1:0] acc_lo1, acc_lo2;
   logic [IDX_W-1:0]  acc_hi1, acc_hi2;
   logic [SIZE_W-1:0] size_clamped;

   assign build_shl = node_ff << shift_ff;
   assign build_lo  = build_shl[IDX_W-1:0];
   assign build_hi  = build_lo | ~({IDX_W{1'b1}} << shift_ff);
   assign node_inc  = node_ff + 1'b1;

   assign path_pos  = cmd.path_sel_b ? req_ff.index_b : req_ff.index_a;
   assign path_val  = cmd.path_sel_b ? va_ff : vb_ff;
   assign path_leaf = {1'b1, path_pos};
   assign step_min  = (rd0_min_ff < cur_min_ff) ? rd0_min_ff : cur_min_ff;
   assign step_max  = (rd0_max_ff > cur_max_ff) ? rd0_max_ff : cur_max_ff;

   always_comb begin
      we    = 1'b0;
      waddr = node_ff;
      wmin  = step_min;
      wmax  = step_max;
      if (cmd.build_step) begin
         we   = 1'b1;
         wmin = {1'b0, build_lo};
         wmax = build_hi;
      end else if (cmd.path_start) begin
         we    = 1'b1;
         waddr = path_leaf;
         wmin  = {1'b0, path_val};
         wmax  = path_val;
      end else if (cmd.path_step) begin
         we = 1'b1;
      end
   end

   assign r_m1     = r_ff - 1'b1;
   assign rd0_addr = cmd.query_step ? l_ff[NODE_W-1:0]
                   : (cmd.path_start ? (path_leaf ^ 11'd1) : (node_ff ^ 11'd1));
   assign rd1_addr = r_m1[NODE_W-1:0];

   assign q_ok = (req_ff.index_a <= req_ff.index_b)
               && ({1'b0, req_ff.index_b} < size_ff);
   assign lt   = l_ff < r_ff;

   // fold the two pending node reads into the running min/max
   assign acc_lo1 = (pl_ff && rd0_min_ff < lo_ff) ? rd0_min_ff : lo_ff;
   assign acc_lo2 = (pr_ff && rd1_min_ff < acc_lo1) ? rd1_min_ff : acc_lo1;
   assign acc_hi1 = (pl_ff && rd0_max_ff > hi_ff) ? rd0_max_ff : hi_ff;
   assign acc_hi2 = (pr_ff && rd1_max_ff > acc_hi1) ? rd1_max_ff : acc_hi1;

   assign size_clamped = (items_ff == '0) ? 11'd1
                       : ((items_ff > MAX_ITEMS) ? MAX_ITEMS : items_ff);

   // tree memories: one write, two registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         min_mem[waddr] <= wmin;
         max_mem[waddr] <= wmax;
      end
      rd0_min_ff <= min_mem[rd0_addr];
      rd0_max_ff <= max_mem[rd0_addr];
      rd1_min_ff <= min_mem[rd1_addr];
      rd1_max_ff <= max_mem[rd1_addr];
   end

   // value store
   always_ff @(posedge clock) begin
      if (cmd.build_step && node_ff[NODE_W-1]) begin
         value_mem[node_ff[IDX_W-1:0]] <= node_ff[IDX_W-1:0];
      end else if (cmd.path_start) begin
         value_mem[path_pos] <= path_val;
      end
      if (cmd.swap_read) begin
         va_ff <= value_mem[req_ff.index_a];
         vb_ff <= value_mem[req_ff.index_b];
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.build_init) begin
         node_ff  <= 11'd1;
         shift_ff <= 4'd10;
      end else if (cmd.build_step) begin
         node_ff <= node_inc;
         if ((node_inc & node_ff) == '0) begin
            shift_ff <= shift_ff - 1'b1;
         end
      end else if (cmd.path_start) begin
         node_ff    <= path_leaf >> 1;
         cur_min_ff <= {1'b0, path_val};
         cur_max_ff <= path_val;
      end else if (cmd.path_step) begin
         node_ff    <= node_ff >> 1;
         cur_min_ff <= step_min;
         cur_max_ff <= step_max;
      end
      if (cmd.query_start) begin
         l_ff     <= q_ok ? {2'b01, req_ff.index_a} : '0;
         r_ff     <= q_ok ? ({2'b01, req_ff.index_b} + 1'b1) : '0;
         lo_ff    <= MAX_ITEMS;
         hi_ff    <= '0;
         empty_ff <= !q_ok;
         pl_ff    <= 1'b0;
         pr_ff    <= 1'b0;
      end else if (cmd.query_step) begin
         pl_ff <= lt & l_ff[0];
         pr_ff <= lt & r_ff[0];
         if (lt) begin
            l_ff <= (l_ff + {{(LR_W-1){1'b0}}, l_ff[0]}) >> 1;
            r_ff <= (r_ff - {{(LR_W-1){1'b0}}, r_ff[0]}) >> 1;
         end
         lo_ff <= acc_lo2;
         hi_ff <= acc_hi2;
      end
   end

   // size register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff     <= SIZE_RESET;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            items_ff <= csr_wr_data;
         end
         if (cmd.size_update) begin
            size_ff <= size_clamped;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.range_min   <= lo_ff;
         rsp_ff.range_max   <= hi_ff;
         rsp_ff.is_exact    <= !empty_ff && (lo_ff == {1'b0, req_ff.index_a})
                               && (hi_ff == req_ff.index_b);
         rsp_ff.range_empty <= empty_ff;
      end
   end

   assign status.build_last = (node_ff == {NODE_W{1'b1}});
   assign status.swap_ok    = ({1'b0, req_ff.index_a} < size_ff)
                            && ({1'b0, req_ff.index_b} < size_ff);
   assign status.path_root  = (node_ff == 11'd1);
   assign status.query_idle = !lt && !pl_ff && !pr_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/range_min_max_swap_tree_core.sv]
// ----------------------------------------------------------------------------
// range_min_max_swap_tree_core
// Swap / range min-max block over a permutation held in a segment tree.
// ----------------------------------------------------------------------------
// Holds a 1024-entry array and two 2048-node trees of minima and maxima.
// A swap (mode 0) exchanges two positions when both lie inside the size:
// after the accept it reads both values, then repairs both leaf-to-root
// paths in turn, one tree level per cycle. A query (mode 1) walks both
// range bounds upward, one level per cycle using the two tree read ports,
// and returns one transfer on the rsp channel: an empty range is fastest,
// a range whose bounds climb all eleven levels is slowest, and a result
// still waiting on the rsp side holds the next one back. An init (mode 2)
// latches the size last written through csr_wr_data (clamped to 1..1024)
// and rebuilds everything by a sweep over all 2047 nodes, one tree node
// per cycle; the same sweep runs after reset, and req_stall stays high
// throughout. Mode 3 is dropped. The tree walks set the rate: one item at
// a time, one level per cycle through the tree memories. A finished result
// sits in the output register while the next request is already taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_min_max_swap_tree_core
   import rmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   rmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // never overwrite a result still waiting on the rsp side
   `ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, status.out_free, "result overwritten")

   // empty ranges carry the fixed sentinel values
   `ASSERT_IMP(a_empty_fmt, clock, reset, rsp_valid && rsp_data.range_empty, (rsp_data.range_min == MAX_ITEMS) && (rsp_data.range_max == '0) && !rsp_data.is_exact, "bad empty result")

   // a non-empty range over a permutation has min not above max
   `ASSERT_IMP(a_min_le_max, clock, reset, rsp_valid && !rsp_data.range_empty, rsp_data.range_min <= {1'b0, rsp_data.range_max}, "min above max")

   // a loaded result shows up on the port next cycle
   `ASSERT_NXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid, "result not presented")

endmodule

[tb/tb_range_min_max_swap_tree_core.sv]
// ----------------------------------------------------------------------------
// tb_range_min_max_swap_tree_core
// Self-checking bench for the swap / range min-max tree block.
// ----------------------------------------------------------------------------
// A behavioral array model predicts every query result (min, max, exact and
// empty flags) from the swaps and inits sent so far. Results are compared in
// order against a queue of predicted query responses. The sender runs in
// bursts with random gaps, the receiver stalls on its own pattern, and one
// long receiver hold-off lets the block back up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_min_max_swap_tree_core;
   import rmm_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int SETTLE_CYCLES = 2200;  // covers a full rebuild sweep
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = SIZE_RESET;

   // predictor state: permutation, register and the size latched at init
   logic [IDX_W-1:0]  perm [ITEMS];
   logic [SIZE_W-1:0] size_reg;
   int unsigned       live_size;

   rsp_type           pending_rsp [$];
   int unsigned       cycle_count = 0;
   int unsigned       error_count = 0;
   bit                hold_rsp = 1'b0;  // forces a long receiver hold-off

   range_min_max_swap_tree_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stall pattern: stretches of free flow, random stalls, or a
   // forced hold while the pressure test runs
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_rsp)
         rsp_stall <= 1'b1;
      else if (stall_phase[9:8] == 2'd0)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // result checker: compare each accepted transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: actual %p", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.range_min !== exp_rsp.range_min) begin
               $display("%0t range_min: expected %0d actual %0d", $time,
                        exp_rsp.range_min, rsp_data.range_min);
               error_count++;
            end
            if (rsp_data.range_max !== exp_rsp.range_max) begin
               $display("%0t range_max: expected %0d actual %0d", $time,
                        exp_rsp.range_max, rsp_data.range_max);
               error_count++;
            end
            if (rsp_data.is_exact !== exp_rsp.is_exact) begin
               $display("%0t is_exact: expected %0b actual %0b", $time,
                        exp_rsp.is_exact, rsp_data.is_exact);
               error_count++;
            end
            if (rsp_data.range_empty !== exp_rsp.range_empty) begin
               $display("%0t range_empty: expected %0b actual %0b", $time,
                        exp_rsp.range_empty, rsp_data.range_empty);
               error_count++;
            end
         end
      end
   end

   // identity fill, with the size taken from the register and clamped
   function automatic void fill_identity();
      for (int i = 0; i < ITEMS; i++) perm[i] = IDX_W'(i);
      if (size_reg == 0) live_size = 1;
      else if (size_reg > MAX_ITEMS) live_size = MAX_ITEMS;
      else live_size = size_reg;
   endfunction

   // advance the array model by one request; queries yield a prediction
   function automatic void apply_request(req_type req);
      rsp_type     r;
      logic [IDX_W-1:0] held;
      int unsigned lo, hi;
      case (req.mode)
         MODE_SWAP: begin
            if (req.index_a < live_size && req.index_b < live_size) begin
               held = perm[req.index_a];
               perm[req.index_a] = perm[req.index_b];
               perm[req.index_b] = held;
            end
         end
         MODE_INIT: fill_identity();
         MODE_QUERY: begin
            lo = MAX_ITEMS;
            hi = 0;
            r = '0;
            if (req.index_a <= req.index_b && req.index_b < live_size) begin
               for (int i = req.index_a; i <= req.index_b; i++) begin
                  if (perm[i] < lo) lo = perm[i];
                  if (perm[i] > hi) hi = perm[i];
               end
               r.is_exact = (lo == req.index_a) && (hi == req.index_b);
            end else
               r.range_empty = 1'b1;
            r.range_min = SIZE_W'(lo);
            r.range_max = IDX_W'(hi);
            pending_rsp.push_back(r);
         end
         default: ;  // unused mode: dropped
      endcase
   endfunction

   // one request transfer; valid stays high across back-to-back items
   task automatic send_request(input logic [1:0] mode, input int a, input int b);
      req_type req;
      req.mode    = mode;
      req.index_a = IDX_W'(a);
      req.index_b = IDX_W'(b);
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(req);
   endtask

   task automatic idle_request(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drain outstanding results, then let any swap or rebuild finish
   task automatic wait_drained();
      idle_request(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SIZE_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_reg = SIZE_W'(value);
   endtask

   // random item mix: mostly swaps and queries inside the size in use,
   // some out of range, rare init and unused mode
   task automatic send_random(input int count, input int init_pct);
      int a, b, pick, burst;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            idle_request($urandom_range(0, 6));
            burst = $urandom_range(1, 12);
         end
         burst--;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, ITEMS - 1);
            b = $urandom_range(0, ITEMS - 1);
         end else begin
            a = $urandom_range(0, live_size - 1);
            b = $urandom_range(a, (a + 40 < live_size) ? a + 40 : live_size - 1);
            if ($urandom_range(0, 7) == 0) b = $urandom_range(a, live_size - 1);
         end
         if (pick < init_pct) send_request(MODE_INIT, a, b);
         else if (pick < init_pct + 2) send_request(MODE_UNUSED, a, b);
         else if (pick < 50) send_request(MODE_SWAP, a, b);
         else if ($urandom_range(0, 5) == 0) send_request(MODE_QUERY, b, a);
         else send_request(MODE_QUERY, a, b);
      end
   endtask

   // field extremes, every mode, reversed (empty) ranges, unused mode
   task automatic test_directed();
      send_request(MODE_QUERY, 0, ITEMS - 1);
      send_request(MODE_QUERY, 0, 0);
      send_request(MODE_QUERY, ITEMS - 1, ITEMS - 1);
      send_request(MODE_QUERY, ITEMS - 1, 0);
      send_request(MODE_SWAP, 0, ITEMS - 1);
      send_request(MODE_QUERY, 0, 0);
      send_request(MODE_QUERY, 0, ITEMS - 1);
      send_request(MODE_SWAP, 5, 5);
      send_request(MODE_SWAP, 341, 682);
      send_request(MODE_QUERY, 341, 682);
      send_request(MODE_UNUSED, 3, 7);
      send_request(MODE_QUERY, 1, 1022);
      send_request(MODE_INIT, 0, 0);
      send_request(MODE_QUERY, 0, ITEMS - 1);
      send_request(MODE_QUERY, 682, 341);
      wait_drained();
   endtask

   // small sizes, including zero and above the limit (clamped at init)
   task automatic test_sizes();
      write_size(0);
      send_request(MODE_INIT, 0, 0);
      send_request(MODE_QUERY, 0, 0);
      send_request(MODE_QUERY, 0, 1);
      send_request(MODE_SWAP, 0, 1);
      send_request(MODE_QUERY, 0, 0);
      wait_drained();
      write_size(2047);
      send_request(MODE_INIT, 0, 0);
      send_request(MODE_QUERY, 0, ITEMS - 1);
      wait_drained();
      write_size(2);
      send_request(MODE_INIT, 0, 0);
      send_request(MODE_SWAP, 0, 1);
      send_request(MODE_QUERY, 0, 1);
      send_request(MODE_QUERY, 1, 2);
      send_request(MODE_SWAP, 1, 2);
      send_request(MODE_QUERY, 0, 0);
      send_random(100, 0);
      wait_drained();
   endtask

   // random traffic over several sizes, extremes among them
   task automatic test_random();
      int sizes [5] = '{1024, 17, 1, 300, 1000};
      foreach (sizes[i]) begin
         write_size(sizes[i]);
         send_request(MODE_INIT, 0, 0);
         send_random(i == 0 ? 500 : 180, 1);
         wait_drained();
      end
   endtask

   // receiver holds off long while queries keep coming: the block backs up
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int n = 0; n < 20; n++)
            send_request(MODE_QUERY, $urandom_range(0, 500), $urandom_range(500, 1023));
      join
      wait_drained();
   endtask

   initial begin
      size_reg = SIZE_RESET;
      fill_identity();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_sizes();
      test_backpressure();
      test_random();
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
